// ----- rtl/sec_pkg.sv -----
// ----------------------------------------------------------------------------
// sec_pkg: shared types and constants for the string escape collapser
// Phase codes, character codes, queue geometry and the decode helpers.
// ----------------------------------------------------------------------------
package sec_pkg;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChX      = 8'h78;
    localparam logic [7:0] ChC      = 8'h63;
    localparam logic [7:0] ChR      = 8'h72;
    localparam logic [7:0] ChN      = 8'h6E;
    localparam logic [7:0] ChT      = 8'h74;
    localparam logic [7:0] ChP      = 8'h70;
    localparam logic [7:0] ChO      = 8'h6F;
    localparam logic [7:0] Ch0      = 8'h30;
    localparam logic [7:0] Ch9      = 8'h39;
    localparam logic [7:0] ChUpA    = 8'h41;
    localparam logic [7:0] ChUpF    = 8'h46;
    localparam logic [7:0] ChLoA    = 8'h61;
    localparam logic [7:0] ChLoF    = 8'h66;

    localparam logic [7:0] CodeCr   = 8'd13;
    localparam logic [7:0] CodeLf   = 8'd10;
    localparam logic [7:0] CodeTab  = 8'd9;
    localparam logic [7:0] CtlR     = 8'd15;
    localparam logic [7:0] CtlP     = 8'd16;
    localparam logic [7:0] CtlO     = 8'd17;
    localparam logic [7:0] LeadOne  = 8'h01;
    localparam logic [7:0] LeadPre  = 8'h02;

    typedef enum logic [2:0] {
        PH_PLAIN = 3'd0,
        PH_ESC   = 3'd1,
        PH_HEX0  = 3'd2,
        PH_HEX1  = 3'd3,
        PH_CTL   = 3'd4
    } t_phase;

    // One queue entry: one or two decoded bytes from a single input beat.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       two;
        logic       run_last;
        logic       bad_escape;
    } t_entry;

    // Hex digit decode: bit 4 set when the character is a valid digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= Ch0 && c <= Ch9) begin
            r = {1'b1, 4'(c - Ch0)};
        end else if (c >= ChUpA && c <= ChUpF) begin
            r = {1'b1, 4'(c - ChUpA + 8'd10)};
        end else if (c >= ChLoA && c <= ChLoF) begin
            r = {1'b1, 4'(c - ChLoA + 8'd10)};
        end
        return r;
    endfunction

    function automatic logic [7:0] plain_escape(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == ChR) begin
            r = CodeCr;
        end else if (c == ChN) begin
            r = CodeLf;
        end else if (c == ChT) begin
            r = CodeTab;
        end
        return r;
    endfunction

    // Remap of control digits 0..9.
    function automatic logic [7:0] ctl_digit(input logic [3:0] d);
        logic [7:0] r;
        r = 8'h01;
        unique case (d)
            4'd0:    r = 8'h01;
            4'd1:    r = 8'h02;
            4'd2:    r = 8'h03;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h05;
            4'd5:    r = 8'h06;
            4'd6:    r = 8'h07;
            4'd7:    r = 8'h0B;
            4'd8:    r = 8'h0C;
            4'd9:    r = 8'h0E;
            default: r = 8'h01;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/sec_front.sv -----
// ----------------------------------------------------------------------------
// sec_front: input side of the escape collapser
// Track the escape phase, classify each raw byte and push decoded bytes.
// ----------------------------------------------------------------------------
module sec_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_raw_byte,
    input  logic            i_end_of_literal,
    output logic            o_push,
    output sec_pkg::t_entry o_entry
);

    sec_pkg::t_phase r_phase, n_phase;
    logic [3:0]      r_hi, n_hi;
    logic            r_hi_ok, n_hi_ok;
    logic            r_emitted, n_emitted;
    logic            r_err, n_err;

    logic [4:0]      hex_b;
    logic [1:0]      cnt;
    logic [7:0]      b0, b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= sec_pkg::PH_PLAIN;
            r_hi      <= 4'd0;
            r_hi_ok   <= 1'b0;
            r_emitted <= 1'b0;
            r_err     <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_hi      <= n_hi;
            r_hi_ok   <= n_hi_ok;
            r_emitted <= n_emitted;
            r_err     <= n_err;
        end
    end

    always_comb begin
        hex_b     = sec_pkg::hex_digit(i_raw_byte);
        n_phase   = r_phase;
        n_hi      = r_hi;
        n_hi_ok   = r_hi_ok;
        n_err     = r_err;
        cnt       = 2'd0;
        b0        = i_raw_byte;
        b1        = i_raw_byte;
        if (!r_err) begin
            unique case (r_phase)
                sec_pkg::PH_PLAIN: begin
                    if (i_raw_byte == sec_pkg::ChBslash && !i_end_of_literal) begin
                        n_phase = sec_pkg::PH_ESC;
                    end else begin
                        cnt = 2'd1;
                    end
                end
                sec_pkg::PH_ESC: begin
                    if (i_raw_byte == sec_pkg::ChX && !i_end_of_literal) begin
                        n_phase = sec_pkg::PH_HEX0;
                    end else if (i_raw_byte == sec_pkg::ChC && !i_end_of_literal) begin
                        n_phase = sec_pkg::PH_CTL;
                    end else begin
                        cnt     = 2'd1;
                        b0      = sec_pkg::plain_escape(i_raw_byte);
                        n_phase = sec_pkg::PH_PLAIN;
                    end
                end
                sec_pkg::PH_HEX0: begin
                    if (i_end_of_literal) begin
                        // cut short: emit the 'x' and the lone character
                        cnt     = 2'd2;
                        b0      = sec_pkg::ChX;
                        n_phase = sec_pkg::PH_PLAIN;
                    end else begin
                        n_hi    = hex_b[3:0];
                        n_hi_ok = hex_b[4];
                        n_phase = sec_pkg::PH_HEX1;
                    end
                end
                sec_pkg::PH_HEX1: begin
                    if (r_hi_ok && hex_b[4]) begin
                        cnt = 2'd1;
                        b0  = {r_hi, hex_b[3:0]};
                    end else begin
                        n_err = 1'b1;
                    end
                    n_phase = sec_pkg::PH_PLAIN;
                end
                sec_pkg::PH_CTL: begin
                    cnt = 2'd1;
                    if (i_raw_byte == sec_pkg::ChR) begin
                        b0 = sec_pkg::CtlR;
                    end else if (i_raw_byte == sec_pkg::ChP) begin
                        b0 = sec_pkg::CtlP;
                    end else if (i_raw_byte == sec_pkg::ChO) begin
                        b0 = sec_pkg::CtlO;
                    end else if (i_raw_byte >= sec_pkg::Ch0 && i_raw_byte <= sec_pkg::Ch9) begin
                        b0 = sec_pkg::ctl_digit(4'(i_raw_byte - sec_pkg::Ch0));
                    end else begin
                        cnt   = 2'd0;
                        n_err = 1'b1;
                    end
                    // leading 0x1 of a literal becomes 0x2 then 0x1
                    if (cnt != 2'd0 && b0 == sec_pkg::LeadOne && !r_emitted) begin
                        cnt = 2'd2;
                        b0  = sec_pkg::LeadPre;
                        b1  = sec_pkg::LeadOne;
                    end
                    n_phase = sec_pkg::PH_PLAIN;
                end
                default: begin
                    cnt     = 2'd1;
                    n_phase = sec_pkg::PH_PLAIN;
                end
            endcase
        end

        n_emitted = r_emitted | (cnt != 2'd0);

        o_entry.byte0      = b0;
        o_entry.byte1      = b1;
        o_entry.two        = (cnt == 2'd2);
        o_entry.run_last   = i_end_of_literal;
        o_entry.bad_escape = 1'b0;
        o_push             = i_accept && (cnt != 2'd0);

        if (i_end_of_literal) begin
            if (n_err) begin
                o_entry.byte0      = 8'd0;
                o_entry.byte1      = 8'd0;
                o_entry.two        = 1'b0;
                o_entry.bad_escape = 1'b1;
                o_push             = i_accept;
            end
            // return to reset state for the next literal
            n_phase   = sec_pkg::PH_PLAIN;
            n_hi      = 4'd0;
            n_hi_ok   = 1'b0;
            n_emitted = 1'b0;
            n_err     = 1'b0;
        end
    end

`ifndef ASSERT_OFF
    a_err_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> r_phase == sec_pkg::PH_PLAIN)
        else $error("error state outside plain phase");
    a_last_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_of_literal) |-> o_push)
        else $error("final beat of a literal produced no result");
    a_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_of_literal) |=> (!r_err && !r_emitted))
        else $error("literal state not cleared after final beat");
`endif

endmodule

// ----- rtl/sec_fifo.sv -----
// ----------------------------------------------------------------------------
// sec_fifo: short entry queue between front and back
// Register-based FIFO with a fill count; read data shows the head entry.
// ----------------------------------------------------------------------------
module sec_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sec_pkg::t_entry i_entry,
    input  logic            i_pop,
    output sec_pkg::t_entry o_head,
    output logic            o_empty,
    output logic            o_full
);

    sec_pkg::t_entry            r_mem [sec_pkg::QDepth];
    logic [sec_pkg::QAw-1:0]    r_wr, r_rd;
    logic [sec_pkg::QAw:0]      r_cnt, n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (sec_pkg::QAw+1)'(sec_pkg::QDepth));

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (sec_pkg::QAw+1)'(sec_pkg::QDepth))
        else $error("queue count out of range");
`endif

endmodule

// ----- rtl/sec_back.sv -----
// ----------------------------------------------------------------------------
// sec_back: output side of the escape collapser
// Hold one queue entry and send its one or two bytes as output beats.
// ----------------------------------------------------------------------------
module sec_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sec_pkg::t_entry i_head,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_decoded_byte,
    output logic            o_run_last,
    output logic            o_bad_escape
);

    sec_pkg::t_entry r_ent;
    logic            r_full;
    logic            r_half;
    logic            fire;
    logic            done;

    assign fire  = r_full && !i_stall;
    // entry finished when its final byte goes out
    assign done  = fire && (r_half || !r_ent.two);
    assign o_pop = (!r_full || done) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_half <= 1'b0;
        end else if (!r_full || done) begin
            r_full <= !i_empty;
            r_half <= 1'b0;
        end else if (fire) begin
            r_half <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_head;
        end
    end

    assign o_valid        = r_full;
    assign o_decoded_byte = r_half ? r_ent.byte1 : r_ent.byte0;
    assign o_run_last     = r_ent.run_last && (r_half || !r_ent.two);
    assign o_bad_escape   = r_ent.bad_escape;

`ifndef ASSERT_OFF
    a_half_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (r_full && r_ent.two))
        else $error("second byte phase on a single-byte entry");
    a_half_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_ent.two && !r_half) |=> r_half)
        else $error("second byte skipped");
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_escape) |-> (o_run_last && o_decoded_byte == 8'd0))
        else $error("error beat not a zero final beat");
`endif

endmodule

// ----- rtl/string_escape_collapser.sv -----
// ----------------------------------------------------------------------------
// string_escape_collapser: backslash escape decoder for string literal bodies
// Raw bytes in, decoded bytes out, with a last mark and an error flag on the final beat of a bad literal.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   input   | in        | i_valid / o_stall    | i_raw_byte, i_end_of_literal
//   output  | out       | o_valid / i_stall    | o_decoded_byte, o_run_last,
//           |           |                      | o_bad_escape
//
// One raw byte is taken per cycle while the queue is not full; a beat that
// decodes to two bytes (a cut short hex escape, or a leading control 0x1)
// yields two output beats, and the four-entry queue between front and back
// absorbs that.
// Synchronous active-low reset clears phase, error and queue state.
// o_stall is high only while the queue is full; it does not look at i_valid.
// ----------------------------------------------------------------------------
module string_escape_collapser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_raw_byte,
    input  logic       i_end_of_literal,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_decoded_byte,
    output logic       o_run_last,
    output logic       o_bad_escape
);

    logic            accept;
    logic            push;
    logic            pop;
    logic            empty;
    logic            full;
    sec_pkg::t_entry push_entry;
    sec_pkg::t_entry head;

    // Accept an input beat whenever the queue has room for its entry.
    assign o_stall = full;
    assign accept  = i_valid && !full;

    // Front: escape phase tracking and byte classification.
    sec_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_raw_byte       (i_raw_byte),
        .i_end_of_literal (i_end_of_literal),
        .o_push           (push),
        .o_entry          (push_entry)
    );

    // Queue: decouple classification from output stalls.
    sec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    // Back: drain entries one byte per beat.
    sec_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_decoded_byte (o_decoded_byte),
        .o_run_last     (o_run_last),
        .o_bad_escape   (o_bad_escape)
    );

`ifndef ASSERT_OFF
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_literal) |-> push)
        else $error("final input beat dropped");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && !empty) |-> pop)
        else $error("back idle while queue holds entries");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_escape) |-> o_run_last)
        else $error("error beat without last mark");
`endif

endmodule
